// ===== src/rule_slot_timer_table_unit_assert.svh =====
// Assertion macros for the rule slot timer table.
// Used by the top level; the clock and reset names of that module are assumed.
`ifndef RULE_SLOT_TIMER_TABLE_UNIT_ASSERT_SVH
`define RULE_SLOT_TIMER_TABLE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define RSTT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset.
`define RSTT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RSTT_ASSERT_IMP(lbl, ante, cons, msg)
`define RSTT_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/rstt_pkg.sv =====
// Shared types and constants of the rule slot timer table.
// No dependencies; used by every module of the block.
`default_nettype none
package rstt_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int SLOT_FW       = 4;
    localparam int MASK_W        = 16;
    localparam int TIME_W        = 32;
    localparam int CHECK_W       = 16;

    localparam logic [CHECK_W-1:0] CHECK_RST = 16'd10;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_REG  = 2'd1;
    localparam logic [1:0] OP_DIS  = 2'd2;
    localparam logic [1:0] OP_MASK = 2'd3;

    localparam logic [1:0] KIND_FIRED   = 2'd0;
    localparam logic [1:0] KIND_STARTED = 2'd1;
    localparam logic [1:0] KIND_STOPPED = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0] start;
        logic [TIME_W-1:0] period;
    } t_timer;

    typedef struct packed {
        logic [SLOT_FW-1:0] slot;
        logic [1:0]         kind;
        logic [MASK_W-1:0]  mask;
    } t_event;

    typedef struct packed {
        logic   push;
        logic   flush;
        t_event ev;
    } t_evbuf_req;

    typedef struct packed {
        logic ready;
        logic hold_valid;
    } t_evbuf_sts;

endpackage
`default_nettype wire

// ===== src/rstt_mem.sv =====
// Timer memory: start time and period per slot, one write and one read port.
// Read data is registered. Depends on rstt_pkg.
`default_nettype none
module rstt_mem #(
    parameter int DEPTH  = rstt_pkg::NUM_SLOTS_DEF,
    parameter int ADDR_W = 4
) (
    input  wire                   i_clk,
    input  wire                   i_we,
    input  wire [ADDR_W-1:0]      i_waddr,
    input  wire rstt_pkg::t_timer i_wdata,
    input  wire                   i_re,
    input  wire [ADDR_W-1:0]      i_raddr,
    output rstt_pkg::t_timer      o_rdata
);

    rstt_pkg::t_timer r_mem [DEPTH];
    rstt_pkg::t_timer r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== src/rstt_evbuf.sv =====
// Event buffer: one hold stage plus the output register.
// An event waits in the hold stage until it is known whether it is the last one.
// Depends on rstt_pkg.
`default_nettype none
module rstt_evbuf (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire rstt_pkg::t_evbuf_req i_req,
    output rstt_pkg::t_evbuf_sts      o_sts,
    input  wire                       i_out_stall,
    output logic                      o_out_valid,
    output rstt_pkg::t_event          o_event,
    output logic                      o_last
);

    logic             r_hold_valid, n_hold_valid;
    rstt_pkg::t_event r_hold, n_hold;
    logic             r_out_valid, n_out_valid;
    rstt_pkg::t_event r_out, n_out;
    logic             r_out_last, n_out_last;
    logic             out_free;
    logic             ready;

    assign out_free = !r_out_valid || !i_out_stall;
    assign ready    = !r_hold_valid || out_free;

    always_comb begin
        n_hold_valid = r_hold_valid;
        n_hold       = r_hold;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;
        n_out_last   = r_out_last;
        if (i_req.push && ready) begin
            // A new event proves that the held one is not the last.
            if (r_hold_valid) begin
                n_out_valid = 1'b1;
                n_out       = r_hold;
                n_out_last  = 1'b0;
            end
            n_hold_valid = 1'b1;
            n_hold       = i_req.ev;
        end else if (i_req.flush && r_hold_valid && out_free) begin
            n_out_valid  = 1'b1;
            n_out        = r_hold;
            n_out_last   = 1'b1;
            n_hold_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold     <= n_hold;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    assign o_sts.ready      = ready;
    assign o_sts.hold_valid = r_hold_valid;
    assign o_out_valid      = r_out_valid;
    assign o_event          = r_out;
    assign o_last           = r_out_last;

endmodule
`default_nettype wire

// ===== src/rule_slot_timer_table_unit.sv =====
// Top level of the rule slot timer table: control sequencer, slot flags, config register.
// Depends on rstt_pkg, rstt_mem, rstt_evbuf and rule_slot_timer_table_unit_assert.svh.
`default_nettype none
`include "rule_slot_timer_table_unit_assert.svh"

// The block keeps NUM_SLOTS rule slots. Each slot has an active flag and a
// millisecond timer, one-shot or recurring, whose start time and period sit in a
// small synchronous memory; the active, armed and recurring flags are flip-flops
// cleared by reset, so no clearing pass is needed after reset. Items arrive on a
// valid/stall channel and results leave on another; every event of one item carries
// the full set of slots active after that item, and the final event of the item has
// last set. Register-timer items, disables and too-early ticks need no walk of the
// table. A tick that passes the check-interval test walks the table one slot per
// cycle, unless the output stalls it, through the single read port of the timer
// memory; a set-mask item walks the slots in the same way. A stalled output holds
// the walk: the hold stage and the output register buffer two events, and the walk
// waits when a third is found. The check interval register may be written through
// its own valid/ready port at any time that the block is idle; it is always ready.
module rule_slot_timer_table_unit #(
    parameter int NUM_SLOTS = rstt_pkg::NUM_SLOTS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Configuration write channel.
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [15:0] i_cfg_data,
    // Input channel.
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [1:0]  i_op,
    input  wire  [31:0] i_now_ms,
    input  wire  [3:0]  i_slot_index,
    input  wire  [31:0] i_interval_ms,
    input  wire         i_is_recurring,
    input  wire  [15:0] i_active_mask_in,
    // Output channel.
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [3:0]  o_event_slot,
    output logic [1:0]  o_event_kind,
    output logic [15:0] o_active_mask,
    output logic        o_last
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    // Control state.
    logic [1:0]            r_state, n_state;
    logic [NUM_SLOTS-1:0]  r_active, n_active;
    logic [NUM_SLOTS-1:0]  r_armed, n_armed;
    logic [NUM_SLOTS-1:0]  r_rec, n_rec;
    logic [31:0]           r_last_scan, n_last_scan;
    logic [15:0]           r_check;

    // Per-item working registers.
    logic [SLOT_W-1:0]     r_idx, n_idx;
    logic [1:0]            r_op, n_op;
    logic [31:0]           r_now, n_now;
    logic [NUM_SLOTS-1:0]  r_req, n_req;
    logic [15:0]           r_mask, n_mask;

    // Timer memory ports.
    logic                  mem_we;
    logic [SLOT_W-1:0]     mem_waddr;
    rstt_pkg::t_timer      mem_wdata;
    logic                  mem_re;
    logic [SLOT_W-1:0]     mem_raddr;
    rstt_pkg::t_timer      mem_rdata;

    // Event buffer interface.
    rstt_pkg::t_evbuf_req  ev_req;
    rstt_pkg::t_evbuf_sts  evb_sts;
    rstt_pkg::t_event      out_ev;

    logic                  in_acc;
    logic                  in_range;
    logic [SLOT_W-1:0]     in_slot;
    logic [31:0]           elapsed;
    logic [31:0]           overshoot;
    logic [31:0]           adv_start;
    logic                  due;
    logic                  behind;
    logic                  fire;
    logic                  start_ev;
    logic                  stop_ev;
    logic                  has_ev;
    logic                  step;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign in_range    = (32'(i_slot_index) < NUM_SLOTS);
    assign in_slot     = i_slot_index[SLOT_W-1:0];

    // Expiry test for the slot under the walk; its memory word sits in the read register.
    // A recurring timer advances by one period, and if it is still a whole period
    // behind it snaps to the scan time instead.
    assign elapsed   = r_now - mem_rdata.start;
    assign overshoot = elapsed - mem_rdata.period;
    assign adv_start = mem_rdata.start + mem_rdata.period;
    assign due       = (elapsed >= mem_rdata.period);
    assign behind    = (overshoot >= mem_rdata.period);
    assign fire      = (r_op == rstt_pkg::OP_TICK) && r_armed[r_idx] && r_active[r_idx] && due;

    // Set-mask walk: a slot changes when the requested bit differs from its flag.
    assign start_ev = r_req[r_idx] && !r_active[r_idx];
    assign stop_ev  = !r_req[r_idx] && r_active[r_idx];
    assign has_ev   = (r_op == rstt_pkg::OP_TICK) ? fire : (start_ev || stop_ev);

    // The walk moves on unless it found an event that the buffer cannot take.
    assign step = (r_state == S_SCAN) && (!has_ev || evb_sts.ready);

    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_armed     = r_armed;
        n_rec       = r_rec;
        n_last_scan = r_last_scan;
        n_idx       = r_idx;
        n_op        = r_op;
        n_now       = r_now;
        n_req       = r_req;
        n_mask      = r_mask;

        mem_we           = 1'b0;
        mem_waddr        = r_idx;
        mem_wdata.start  = behind ? r_now : adv_start;
        mem_wdata.period = mem_rdata.period;
        mem_re           = 1'b0;
        mem_raddr        = r_idx + 1'b1;

        ev_req.push    = 1'b0;
        ev_req.flush   = 1'b0;
        ev_req.ev.slot = 4'(r_idx);
        ev_req.ev.kind = rstt_pkg::KIND_FIRED;
        ev_req.ev.mask = r_mask;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_op)
                        rstt_pkg::OP_TICK: begin
                            if ((i_now_ms - r_last_scan) >= 32'(r_check)) begin
                                n_last_scan = i_now_ms;
                                n_now       = i_now_ms;
                                n_op        = i_op;
                                n_idx       = '0;
                                n_mask      = 16'(r_active);
                                mem_re      = 1'b1;
                                mem_raddr   = '0;
                                n_state     = S_SCAN;
                            end
                        end
                        rstt_pkg::OP_REG: begin
                            if (in_range) begin
                                mem_we           = 1'b1;
                                mem_waddr        = in_slot;
                                mem_wdata.start  = i_now_ms;
                                mem_wdata.period = i_interval_ms;
                                n_armed[in_slot] = (i_interval_ms != 32'd0);
                                n_rec[in_slot]   = i_is_recurring;
                            end
                        end
                        rstt_pkg::OP_DIS: begin
                            if (in_range && r_active[in_slot]) begin
                                n_active[in_slot] = 1'b0;
                                n_armed[in_slot]  = 1'b0;
                                // The hold stage is always empty when idle.
                                ev_req.push       = 1'b1;
                                ev_req.ev.slot    = i_slot_index;
                                ev_req.ev.kind    = rstt_pkg::KIND_STOPPED;
                                ev_req.ev.mask    = 16'(n_active);
                                n_state           = S_DRAIN;
                            end
                        end
                        rstt_pkg::OP_MASK: begin
                            n_req   = i_active_mask_in[NUM_SLOTS-1:0];
                            n_mask  = 16'(i_active_mask_in[NUM_SLOTS-1:0]);
                            n_op    = i_op;
                            n_idx   = '0;
                            n_state = S_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (step) begin
                    if (has_ev) begin
                        ev_req.push = 1'b1;
                        if (r_op == rstt_pkg::OP_TICK) begin
                            ev_req.ev.kind = rstt_pkg::KIND_FIRED;
                            if (r_rec[r_idx]) begin
                                mem_we = 1'b1;
                            end else begin
                                n_armed[r_idx] = 1'b0;
                            end
                        end else if (start_ev) begin
                            ev_req.ev.kind  = rstt_pkg::KIND_STARTED;
                            n_active[r_idx] = 1'b1;
                        end else begin
                            ev_req.ev.kind  = rstt_pkg::KIND_STOPPED;
                            n_active[r_idx] = 1'b0;
                            n_armed[r_idx]  = 1'b0;
                        end
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_idx  = r_idx + 1'b1;
                        mem_re = (r_op == rstt_pkg::OP_TICK);
                    end
                end
            end
            S_DRAIN: begin
                // Release the held event, now known to be the last of the item.
                if (evb_sts.hold_valid) begin
                    if (evb_sts.ready) begin
                        ev_req.flush = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_armed     <= '0;
            r_rec       <= '0;
            r_last_scan <= '0;
            r_check     <= rstt_pkg::CHECK_RST;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_armed     <= n_armed;
            r_rec       <= n_rec;
            r_last_scan <= n_last_scan;
            if (i_cfg_valid) begin
                r_check <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_op   <= n_op;
        r_now  <= n_now;
        r_req  <= n_req;
        r_mask <= n_mask;
    end

    rstt_mem #(
        .DEPTH  (NUM_SLOTS),
        .ADDR_W (SLOT_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    rstt_evbuf u_evbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (ev_req),
        .o_sts       (evb_sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_event     (out_ev),
        .o_last      (o_last)
    );

    assign o_event_slot  = out_ev.slot;
    assign o_event_kind  = out_ev.kind;
    assign o_active_mask = out_ev.mask;

    // A write-back during the walk never meets the read of the same entry.
    `RSTT_ASSERT_IMP(a_mem_hazard, mem_we && mem_re, mem_waddr != mem_raddr, "timer memory hazard")
    // The reported mask stays fixed while an item is in progress.
    `RSTT_ASSERT_NXT(a_mask_hold, r_state != S_IDLE, $stable(r_mask), "mask changed mid item")
    // A tick only disarms or advances timers; it never starts or stops a slot.
    `RSTT_ASSERT_NXT(a_tick_flags, (r_state == S_SCAN) && (r_op == rstt_pkg::OP_TICK),
        $stable(r_active), "tick changed active flags")
    // The walk does not end before the last slot.
    `RSTT_ASSERT_NXT(a_scan_end, (r_state == S_SCAN) && (r_idx != LAST_IDX),
        r_state == S_SCAN, "walk ended early")
    // Every event of an item has left the hold stage before the next item.
    `RSTT_ASSERT_IMP(a_idle_empty, r_state == S_IDLE, !evb_sts.hold_valid, "event left behind")

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for rule_slot_timer_table_unit: directed and random
// transactions, checked event by event against a predictor of the slot table.
// Depends on rstt_pkg and the RTL of the block; it reads no files.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS         = rstt_pkg::NUM_SLOTS_DEF;
    // Idle cycles let a walk of the table and the output buffer settle before a
    // register write, since register and too-early tick transactions give no event.
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 300;
    localparam int MAX_REPORTS   = 10;

    // One input transaction, one field per port.
    typedef struct {
        logic [1:0]  op;
        logic [31:0] now;
        logic [3:0]  slot;
        logic [31:0] ival;
        logic        rec;
        logic [15:0] mask;
    } t_cmd;

    // One output transaction.
    typedef struct packed {
        logic [3:0]  slot;
        logic [1:0]  kind;
        logic [15:0] mask;
        logic        last;
    } t_expect;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_op;
    logic [31:0] i_now_ms;
    logic [3:0]  i_slot_index;
    logic [31:0] i_interval_ms;
    logic        i_is_recurring;
    logic [15:0] i_active_mask_in;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [3:0]  o_event_slot;
    logic [1:0]  o_event_kind;
    logic [15:0] o_active_mask;
    logic        o_last;

    rule_slot_timer_table_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_now_ms        (i_now_ms),
        .i_slot_index    (i_slot_index),
        .i_interval_ms   (i_interval_ms),
        .i_is_recurring  (i_is_recurring),
        .i_active_mask_in(i_active_mask_in),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_event_slot    (o_event_slot),
        .o_event_kind    (o_event_kind),
        .o_active_mask   (o_active_mask),
        .o_last          (o_last)
    );

    // Predicted copy of the slot table and of the check interval register.
    bit          slot_on   [SLOTS];
    bit          armed     [SLOTS];
    bit          repeats   [SLOTS];
    logic [31:0] origin_ms [SLOTS];
    logic [31:0] period_ms [SLOTS];
    logic [31:0] scan_ms;
    logic [15:0] scan_gap_ms;

    // Events that the block still owes, oldest first.
    t_expect pending_events[$];

    // Stimulus controls shared by the test tasks and the receiver process.
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_left;
    logic [31:0] clock_ms;

    int error_count;
    int cmds_sent;
    int events_checked;
    int cfg_writes;

    // The clock runs free from time zero.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // A hard ceiling on the run, far beyond the slowest correct run.
    initial begin
        #8_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // The receiver decides its stall at every falling edge. A long hold, once
    // requested by a test, is counted down here cycle by cycle; otherwise the
    // stall is drawn at random with the current idle percentage.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left   <= hold_left - 1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Every accepted output transaction is compared with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            check_event();
        end
    end

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
    endtask

    task automatic check_event();
        t_expect want;
        if (pending_events.size() == 0) begin
            note_error($sformatf("event with none expected: slot %0d kind %0d mask %h last %0b",
                                 o_event_slot, o_event_kind, o_active_mask, o_last));
            return;
        end
        want = pending_events.pop_front();
        events_checked++;
        if (o_event_slot !== want.slot || o_event_kind !== want.kind ||
            o_active_mask !== want.mask || o_last !== want.last) begin
            note_error($sformatf({"event %0d: expected slot %0d kind %0d mask %h last %0b, ",
                                  "got slot %0d kind %0d mask %h last %0b"},
                                 events_checked, want.slot, want.kind, want.mask, want.last,
                                 o_event_slot, o_event_kind, o_active_mask, o_last));
        end
    endtask

    function automatic void clear_table();
        for (int i = 0; i < SLOTS; i++) begin
            slot_on[i]   = 1'b0;
            armed[i]     = 1'b0;
            repeats[i]   = 1'b0;
            origin_ms[i] = '0;
            period_ms[i] = '0;
        end
        scan_ms     = '0;
        scan_gap_ms = rstt_pkg::CHECK_RST;
    endfunction

    // Applies one accepted transaction to the predicted table and queues the
    // events that it causes. Every event carries the active set after the whole
    // transaction, and the final one carries last.
    function automatic void apply_to_table(input t_cmd c);
        t_expect     evs[$];
        t_expect     ev;
        logic [31:0] since;
        logic [15:0] mask_after;
        bit          want;
        case (c.op)
            rstt_pkg::OP_TICK: begin
                since = c.now - scan_ms;
                // A tick inside the check interval changes nothing at all.
                if (since < {16'd0, scan_gap_ms}) begin
                    return;
                end
                scan_ms = c.now;
                for (int i = 0; i < SLOTS; i++) begin
                    if (armed[i] && slot_on[i]) begin
                        since = c.now - origin_ms[i];
                        if (since >= period_ms[i]) begin
                            if (repeats[i]) begin
                                // Advance by one period, and snap to now when the
                                // timer is still a full period behind.
                                origin_ms[i] = origin_ms[i] + period_ms[i];
                                since = c.now - origin_ms[i];
                                if (since >= period_ms[i]) begin
                                    origin_ms[i] = c.now;
                                end
                            end else begin
                                armed[i] = 1'b0;
                            end
                            ev = '{slot: 4'(i), kind: rstt_pkg::KIND_FIRED, mask: '0,
                                   last: 1'b0};
                            evs.push_back(ev);
                        end
                    end
                end
            end
            rstt_pkg::OP_REG: begin
                // Arms even an inactive slot; a zero interval disarms.
                origin_ms[c.slot] = c.now;
                period_ms[c.slot] = c.ival;
                repeats[c.slot]   = c.rec;
                armed[c.slot]     = (c.ival != 0);
            end
            rstt_pkg::OP_DIS: begin
                if (slot_on[c.slot]) begin
                    slot_on[c.slot] = 1'b0;
                    armed[c.slot]   = 1'b0;
                    ev = '{slot: c.slot, kind: rstt_pkg::KIND_STOPPED, mask: '0, last: 1'b0};
                    evs.push_back(ev);
                end
            end
            default: begin
                for (int i = 0; i < SLOTS; i++) begin
                    want = c.mask[i];
                    if (want && !slot_on[i]) begin
                        slot_on[i] = 1'b1;
                        ev = '{slot: 4'(i), kind: rstt_pkg::KIND_STARTED, mask: '0,
                               last: 1'b0};
                        evs.push_back(ev);
                    end else if (!want && slot_on[i]) begin
                        slot_on[i] = 1'b0;
                        armed[i]   = 1'b0;
                        ev = '{slot: 4'(i), kind: rstt_pkg::KIND_STOPPED, mask: '0,
                               last: 1'b0};
                        evs.push_back(ev);
                    end
                end
            end
        endcase
        mask_after = '0;
        for (int i = 0; i < SLOTS; i++) begin
            mask_after[i] = slot_on[i];
        end
        for (int k = 0; k < evs.size(); k++) begin
            ev      = evs[k];
            ev.mask = mask_after;
            ev.last = (k == evs.size() - 1);
            pending_events.push_back(ev);
        end
    endfunction

    // Offers one transaction, after random idle cycles, and holds it until it is
    // accepted. Valid is left high on return, so back-to-back calls keep the
    // channel busy; whoever stops sending lowers it first.
    task automatic send_cmd(input t_cmd c);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_op             <= c.op;
        i_now_ms         <= c.now;
        i_slot_index     <= c.slot;
        i_interval_ms    <= c.ival;
        i_is_recurring   <= c.rec;
        i_active_mask_in <= c.mask;
        do @(posedge i_clk); while (o_in_stall);
        apply_to_table(c);
        cmds_sent++;
        @(negedge i_clk);
    endtask

    // Fields that an operation ignores get random values.
    task automatic tick_at(input logic [31:0] now);
        send_cmd('{rstt_pkg::OP_TICK, now, 4'($urandom_range(15)), $urandom,
                   1'($urandom_range(1)), 16'($urandom_range(16'hFFFF))});
    endtask

    task automatic arm_at(input logic [3:0] slot, input logic [31:0] now,
                          input logic [31:0] ival, input logic rec);
        send_cmd('{rstt_pkg::OP_REG, now, slot, ival, rec, 16'($urandom_range(16'hFFFF))});
    endtask

    task automatic stop_at(input logic [3:0] slot, input logic [31:0] now);
        send_cmd('{rstt_pkg::OP_DIS, now, slot, $urandom, 1'($urandom_range(1)),
                   16'($urandom_range(16'hFFFF))});
    endtask

    task automatic mask_at(input logic [15:0] mask, input logic [31:0] now);
        send_cmd('{rstt_pkg::OP_MASK, now, 4'($urandom_range(15)), $urandom,
                   1'($urandom_range(1)), mask});
    endtask

    // Mostly well-formed traffic on a clock that moves forward, with a share of
    // transactions whose every field is random.
    function automatic t_cmd random_cmd(input int unsigned max_step);
        t_cmd        c;
        int unsigned pick;
        pick     = $urandom_range(99);
        clock_ms = clock_ms + $urandom_range(max_step);
        c.op     = rstt_pkg::OP_TICK;
        c.now    = clock_ms;
        c.slot   = 4'($urandom_range(15));
        c.ival   = $urandom;
        c.rec    = 1'($urandom_range(1));
        c.mask   = 16'($urandom_range(16'hFFFF));
        if (pick < 40) begin
            c.op = rstt_pkg::OP_TICK;
        end else if (pick < 62) begin
            c.op   = rstt_pkg::OP_REG;
            c.ival = ($urandom_range(9) == 0) ? 32'd0 : 32'($urandom_range(80, 1));
        end else if (pick < 72) begin
            c.op = rstt_pkg::OP_DIS;
        end else if (pick < 85) begin
            // Dense masks keep most slots running so that timers can fire.
            c.op   = rstt_pkg::OP_MASK;
            c.mask = c.mask | 16'($urandom_range(16'hFFFF));
        end else begin
            c.op  = 2'($urandom_range(3));
            c.now = $urandom;
        end
        return c;
    endfunction

    // Stops sending, waits until every expected event has arrived, then lets
    // the block finish any walk that produces no event.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_events.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Writes the check interval; only called while the block is idle.
    task automatic write_check_interval(input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        scan_gap_ms = value;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Each special case of the table in a short hand-written sequence, with the
    // reset check interval of ten milliseconds.
    task automatic test_directed_events();
        write_check_interval(rstt_pkg::CHECK_RST);
        send_idle_pct = 20;
        recv_idle_pct = 20;
        tick_at(32'd0);                        // too early right after reset
        tick_at(32'd9);                        // still too early
        mask_at(16'hFFFF, 32'd9);              // every slot starts
        mask_at(16'hFFFF, 32'd9);              // no change, no event
        arm_at(4'd0, 32'd20, 32'd100, 1'b0);
        arm_at(4'd15, 32'd20, 32'd30, 1'b1);
        arm_at(4'd3, 32'd20, 32'd0, 1'b1);     // zero interval leaves it disarmed
        tick_at(32'd25);                       // scans, nothing expired
        tick_at(32'd30);                       // too early again
        tick_at(32'd60);                       // recurring slot fires
        tick_at(32'd200);                      // one-shot fires, recurring snaps to now
        stop_at(4'd15, 32'd200);
        stop_at(4'd15, 32'd200);               // already stopped, ignored
        mask_at(16'h0000, 32'd200);            // every other slot stops
        arm_at(4'd2, 32'd210, 32'd10, 1'b1);   // armed while inactive
        tick_at(32'd230);                      // inactive slot never fires
        mask_at(16'h0004, 32'd230);
        tick_at(32'd240);
        arm_at(4'd5, 32'd240, 32'hFFFF_FFFF, 1'b0);
        mask_at(16'hAAAA, 32'd240);
        mask_at(16'h5555, 32'd240);
        tick_at(32'hFFFF_FFFF);
        wait_for_drain();
    endtask

    // Both extremes of the check interval: zero scans on every tick, the
    // largest value lets only widely spaced ticks through.
    task automatic test_check_interval_extremes();
        write_check_interval(16'd0);
        send_idle_pct = 10;
        recv_idle_pct = 10;
        clock_ms = 32'd1000;
        mask_at(16'hFFFF, clock_ms);
        arm_at(4'd6, clock_ms, 32'd1, 1'b1);
        tick_at(clock_ms);                     // same time as the last scan still scans
        tick_at(clock_ms);
        repeat (30) send_cmd(random_cmd(4));
        wait_for_drain();
        write_check_interval(16'hFFFF);
        repeat (30) send_cmd(random_cmd(40000));
        wait_for_drain();
    endtask

    // Timers that run across the wrap of the millisecond counter.
    task automatic test_timer_wraparound();
        write_check_interval(16'd1);
        send_idle_pct = 15;
        recv_idle_pct = 40;
        clock_ms = 32'hFFFF_FF80;
        mask_at(16'h000F, clock_ms);
        arm_at(4'd0, clock_ms, 32'd25, 1'b1);
        arm_at(4'd1, clock_ms, 32'd40, 1'b0);
        arm_at(4'd2, clock_ms, 32'hFFFF_FFFF, 1'b1);
        arm_at(4'd3, clock_ms, 32'd7, 1'b1);
        repeat (30) begin
            clock_ms = clock_ms + $urandom_range(20);
            tick_at(clock_ms);
        end
        // A long silence leaves the short recurring timers more than a period behind.
        clock_ms = clock_ms + 32'd1000;
        tick_at(clock_ms);
        wait_for_drain();
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering
    // transactions that set and clear the whole mask in turn, so the block fills and stalls.
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = LONG_HOLD;
        for (int n = 0; n < 12; n++) begin
            clock_ms = clock_ms + 32'd15;
            mask_at((n % 2 == 0) ? 16'hFFFF : 16'h0000, clock_ms);
            arm_at(4'(n), clock_ms, 32'd5, 1'(n % 2));
        end
        wait_for_drain();
    endtask

    // The sender stops in the middle of traffic until every event has come back.
    task automatic test_sender_pause();
        send_idle_pct = 0;
        recv_idle_pct = 50;
        repeat (12) send_cmd(random_cmd(20));
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_events.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (12) send_cmd(random_cmd(20));
        wait_for_drain();
    endtask

    task automatic test_random_traffic(input int count, input int s_pct, input int r_pct,
                                       input logic [15:0] gap);
        write_check_interval(gap);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (count) send_cmd(random_cmd(30));
        wait_for_drain();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_data       = '0;
        i_in_valid       = 1'b0;
        i_op             = rstt_pkg::OP_TICK;
        i_now_ms         = '0;
        i_slot_index     = '0;
        i_interval_ms    = '0;
        i_is_recurring   = 1'b0;
        i_active_mask_in = '0;
        send_idle_pct    = 0;
        recv_idle_pct    = 0;
        hold_left        = 0;
        clock_ms         = '0;
        error_count      = 0;
        cmds_sent        = 0;
        events_checked   = 0;
        cfg_writes       = 0;
        clear_table();

        // Synchronous reset, held low from time zero and released mid-cycle.
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_events();
        test_check_interval_extremes();
        test_timer_wraparound();
        test_output_backpressure();
        test_sender_pause();
        test_random_traffic(80, 30, 81, 16'($urandom_range(25)));
        test_random_traffic(80, 81, 30, 16'($urandom_range(25)));
        test_random_traffic(80, 0, 0, 16'($urandom_range(25)));

        $display("Covered %0d transactions in, %0d events out, %0d interval writes, %0d mismatches.",
                 cmds_sent, events_checked, cfg_writes, error_count);
        $display("Phases: directed cases, interval extremes, counter wrap, long hold, pause, random.");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
